/* src/bidp_pkg.sv */
// Shared types and constants for the bulk int7 dot-product unit.
package bidp_pkg;

    localparam int MAX_DIMS = 4096;
    localparam int POS_W    = $clog2(MAX_DIMS);
    localparam int LEN_W    = 13;
    localparam int ELEM_W   = 7;
    localparam int TAG_W    = 31;
    localparam int SUM_W    = 26;
    localparam int PROD_W   = 2 * ELEM_W;

    // Depth of the queue between front and back, and of the result queue.
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCNT_W   = $clog2(QDEPTH + 1);

    typedef enum logic {
        MODE_QUERY = 1'b0,
        MODE_ROW   = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic [ELEM_W-1:0]  element;
        logic [TAG_W-1:0]   row_index;
    } t_in_beat;

    typedef struct packed {
        logic [SUM_W-1:0]   dot_sum;
        logic [TAG_W-1:0]   row_tag;
    } t_out_beat;

    // One row element paired with its query element, as passed front to back.
    typedef struct packed {
        logic [ELEM_W-1:0]  element;
        logic [ELEM_W-1:0]  query;
        logic               last;
        logic [TAG_W-1:0]   tag;
    } t_row_beat;

endpackage

/* src/bidp_front.sv */
// Front end: query store, position counters and the operand fetch stage.
module bidp_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_wr_en,
    input  logic [bidp_pkg::LEN_W-1:0] i_cfg_wr_data,
    input  logic                       i_push,
    input  bidp_pkg::t_in_beat         i_in_beat,
    output logic                       o_full,
    output logic                       o_valid,
    input  logic                       i_ready,
    output bidp_pkg::t_row_beat        o_row
);

    logic [bidp_pkg::ELEM_W-1:0] r_mem [bidp_pkg::MAX_DIMS];

    logic [bidp_pkg::POS_W-1:0]  r_fill, n_fill;
    logic [bidp_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [bidp_pkg::POS_W-1:0]  r_last_pos, n_last_pos;
    logic                        r_s1_valid, n_s1_valid;
    logic [bidp_pkg::ELEM_W-1:0] r_s1_elem;
    logic [bidp_pkg::ELEM_W-1:0] r_s1_query;
    logic                        r_s1_last;
    logic [bidp_pkg::TAG_W-1:0]  r_s1_tag;
    logic [bidp_pkg::LEN_W-1:0]  w_len;
    logic                        w_accept;
    logic                        w_advance;
    logic                        w_is_row;

    assign w_advance = r_s1_valid && i_ready;
    assign o_full    = r_s1_valid && !i_ready;
    assign w_accept  = i_push && !o_full;
    assign w_is_row  = (i_in_beat.mode == bidp_pkg::MODE_ROW);

    // Clamp the written length into 1..MAX_DIMS.
    always_comb begin
        if (i_cfg_wr_data == '0) begin
            w_len = bidp_pkg::LEN_W'(1);
        end else if (int'(i_cfg_wr_data) > bidp_pkg::MAX_DIMS) begin
            w_len = bidp_pkg::LEN_W'(bidp_pkg::MAX_DIMS);
        end else begin
            w_len = i_cfg_wr_data;
        end
    end

    always_comb begin
        n_fill     = r_fill;
        n_pos      = r_pos;
        n_last_pos = r_last_pos;
        n_s1_valid = r_s1_valid;
        if (w_advance) begin
            n_s1_valid = 1'b0;
        end
        if (i_cfg_wr_en) begin
            n_last_pos = bidp_pkg::POS_W'(w_len - 1'b1);
            n_fill     = '0;
            n_pos      = '0;
        end else if (w_accept) begin
            if (w_is_row) begin
                n_s1_valid = 1'b1;
                n_pos      = (r_pos == r_last_pos) ? '0 : r_pos + 1'b1;
            end else begin
                n_fill     = (r_fill == r_last_pos) ? '0 : r_fill + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_pos      <= '0;
            r_last_pos <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_fill     <= n_fill;
            r_pos      <= n_pos;
            r_last_pos <= n_last_pos;
            r_s1_valid <= n_s1_valid;
        end
    end

    // Query store: one write port at the fill count, one read port at the row position.
    always_ff @(posedge i_clk) begin
        if (w_accept && !w_is_row) begin
            r_mem[r_fill] <= i_in_beat.element;
        end
        if (w_accept && w_is_row) begin
            r_s1_query <= r_mem[r_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_is_row) begin
            r_s1_elem <= i_in_beat.element;
            r_s1_last <= (r_pos == r_last_pos);
            r_s1_tag  <= i_in_beat.row_index;
        end
    end

    assign o_valid       = r_s1_valid;
    assign o_row.element = r_s1_elem;
    assign o_row.query   = r_s1_query;
    assign o_row.last    = r_s1_last;
    assign o_row.tag     = r_s1_tag;

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos <= r_last_pos) && (r_fill <= r_last_pos))
        else $error("row or query position beyond vector length");

    a_query_no_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_is_row && !i_cfg_wr_en) |=> !r_s1_valid)
        else $error("query beat produced an operand beat");

endmodule

/* src/bidp_mid_queue.sv */
// Short queue of operand beats between front end and MAC back end.
module bidp_mid_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr_valid,
    output logic                o_wr_ready,
    input  bidp_pkg::t_row_beat i_wr_data,
    output logic                o_rd_valid,
    input  logic                i_rd_ready,
    output bidp_pkg::t_row_beat o_rd_data
);

    bidp_pkg::t_row_beat          r_store [bidp_pkg::QDEPTH];
    logic [bidp_pkg::QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [bidp_pkg::QCNT_W-1:0]  r_count;
    logic                         w_push, w_pop;

    assign o_wr_ready = (r_count != bidp_pkg::QCNT_W'(bidp_pkg::QDEPTH));
    assign o_rd_valid = (r_count != '0);
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;
    assign o_rd_data  = r_store[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + bidp_pkg::QCNT_W'(w_push) - bidp_pkg::QCNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_store[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

/* src/bidp_back.sv */
// Back end: multiply-accumulate over row beats and the result queue.
module bidp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_clear,
    input  logic                i_valid,
    output logic                o_ready,
    input  bidp_pkg::t_row_beat i_row,
    output logic                o_empty,
    input  logic                i_pop,
    output bidp_pkg::t_out_beat o_out_beat
);

    logic [bidp_pkg::SUM_W-1:0]   r_acc, n_acc;
    logic [bidp_pkg::PROD_W-1:0]  w_prod;
    logic [bidp_pkg::SUM_W:0]     w_sum;
    logic [bidp_pkg::SUM_W-1:0]   w_sat;
    logic                         w_take;
    logic                         w_res_push, w_res_pop, w_res_full;

    bidp_pkg::t_out_beat          r_res [bidp_pkg::QDEPTH];
    logic [bidp_pkg::QPTR_W-1:0]  r_res_wr, r_res_rd;
    logic [bidp_pkg::QCNT_W-1:0]  r_res_count;

    assign w_res_full = (r_res_count == bidp_pkg::QCNT_W'(bidp_pkg::QDEPTH));
    assign o_empty    = (r_res_count == '0);
    assign w_res_pop  = i_pop && !o_empty;

    // Stall only a row's closing beat when there is no room for its result.
    assign o_ready    = !i_row.last || !w_res_full;
    assign w_take     = i_valid && o_ready;
    assign w_res_push = w_take && i_row.last;

    assign w_prod = bidp_pkg::PROD_W'(i_row.element) * bidp_pkg::PROD_W'(i_row.query);
    assign w_sum  = {1'b0, r_acc} + (bidp_pkg::SUM_W + 1)'(w_prod);
    assign w_sat  = w_sum[bidp_pkg::SUM_W] ? '1 : w_sum[bidp_pkg::SUM_W-1:0];

    always_comb begin
        n_acc = r_acc;
        if (i_clear) begin
            n_acc = '0;
        end else if (w_take) begin
            n_acc = i_row.last ? '0 : w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_res_wr    <= '0;
            r_res_rd    <= '0;
            r_res_count <= '0;
        end else begin
            r_acc <= n_acc;
            if (w_res_push) begin
                r_res_wr <= r_res_wr + 1'b1;
            end
            if (w_res_pop) begin
                r_res_rd <= r_res_rd + 1'b1;
            end
            r_res_count <= r_res_count + bidp_pkg::QCNT_W'(w_res_push)
                           - bidp_pkg::QCNT_W'(w_res_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_push) begin
            r_res[r_res_wr].dot_sum <= w_sat;
            r_res[r_res_wr].row_tag <= i_row.tag;
        end
    end

    assign o_out_beat = r_res[r_res_rd];

    a_res_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_res_count <= bidp_pkg::QCNT_W'(bidp_pkg::QDEPTH))
        else $error("result queue overflow");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |=> !o_empty)
        else $error("closing beat left no result");

endmodule

/* src/bulk_int7_dot_product_unit.sv */
// Top level of the bulk int7 dot-product unit: front end, operand queue, MAC back end.
// Path: a row's closing beat, once accepted, is registered in the front fetch stage,
//   written into the operand queue, then taken by the MAC, which pushes its result (o_empty low).
// Throughput: one beat per cycle, query or row, unless full is raised by back-pressure; the
//   single-port-read query store and the one multiply-accumulate per cycle set that rate.
// Reset: synchronous, active low; clears counters, accumulator, queues and sets the
//   vector length to one. The query store is not cleared and reads undefined until loaded.
module bulk_int7_dot_product_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration: vector length, to be written while the unit is idle; the block does not enforce this.
    input  logic                       i_cfg_wr_en,
    input  logic [bidp_pkg::LEN_W-1:0] i_cfg_wr_data,
    // Input queue side.
    input  logic                       push,
    input  bidp_pkg::t_in_beat         i_in_beat,
    output logic                       full,
    // Result queue side.
    output logic                       empty,
    input  logic                       pop,
    output bidp_pkg::t_out_beat        o_out_beat
);

    // Operand beats between front and back.
    logic                 w_f_valid;
    logic                 w_f_ready;
    bidp_pkg::t_row_beat  w_f_row;
    logic                 w_b_valid;
    logic                 w_b_ready;
    bidp_pkg::t_row_beat  w_b_row;

    // Front: write query beats into the store, fetch the matching query
    // element for each row beat and flag a row's closing beat.
    bidp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_push        (push),
        .i_in_beat     (i_in_beat),
        .o_full        (full),
        .o_valid       (w_f_valid),
        .i_ready       (w_f_ready),
        .o_row         (w_f_row)
    );

    // Decouple: hold operand beats while the back end waits on the consumer.
    bidp_mid_queue u_mid_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_f_valid),
        .o_wr_ready (w_f_ready),
        .i_wr_data  (w_f_row),
        .o_rd_valid (w_b_valid),
        .i_rd_ready (w_b_ready),
        .o_rd_data  (w_b_row)
    );

    // Back: accumulate products, push the saturated sum with the closing beat's tag.
    // A config write also drops any partial row sum.
    bidp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clear    (i_cfg_wr_en),
        .i_valid    (w_b_valid),
        .o_ready    (w_b_ready),
        .i_row      (w_b_row),
        .o_empty    (empty),
        .i_pop      (pop),
        .o_out_beat (o_out_beat)
    );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the bulk int7 dot-product unit.

// Tracks the query vector and row accumulation to predict every dot-product result.
class dot_scoreboard;
    logic [bidp_pkg::ELEM_W-1:0] query_mem [bidp_pkg::MAX_DIMS];
    int unsigned                 fill_pos;
    int unsigned                 row_pos;
    int unsigned                 run_sum;
    logic [bidp_pkg::LEN_W-1:0]  length_reg;
    bidp_pkg::t_out_beat         expected_q [$];
    int unsigned                 mismatches;

    function new();
        fill_pos   = 0;
        row_pos    = 0;
        run_sum    = 0;
        length_reg = bidp_pkg::LEN_W'(1);
        mismatches = 0;
    endfunction

    function int unsigned span();
        if (length_reg == 0) return 1;
        if (length_reg > bidp_pkg::MAX_DIMS) return bidp_pkg::MAX_DIMS;
        return length_reg;
    endfunction

    function void set_length(logic [bidp_pkg::LEN_W-1:0] v);
        length_reg = v;
        fill_pos   = 0;
        row_pos    = 0;
        run_sum    = 0;
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    function void note_beat(bidp_pkg::t_in_beat b);
        int unsigned         len;
        int unsigned         prod;
        bidp_pkg::t_out_beat res;
        len = span();
        if (b.mode == bidp_pkg::MODE_QUERY) begin
            if (fill_pos >= len) fill_pos = 0;
            query_mem[fill_pos] = b.element;
            fill_pos++;
            if (fill_pos >= len) fill_pos = 0;
        end else begin
            if (row_pos >= len) row_pos = 0;
            prod    = int'(b.element) * int'(query_mem[row_pos]);
            run_sum = (run_sum + prod > (1 << bidp_pkg::SUM_W) - 1) ?
                      (1 << bidp_pkg::SUM_W) - 1 : run_sum + prod;
            row_pos++;
            if (row_pos >= len) begin
                res.dot_sum = run_sum[bidp_pkg::SUM_W-1:0];
                res.row_tag = b.row_index;
                expected_q.push_back(res);
                run_sum = 0;
                row_pos = 0;
            end
        end
    endfunction

    function void check_result(bidp_pkg::t_out_beat got);
        bidp_pkg::t_out_beat want;
        if (expected_q.size() == 0) begin
            if (mismatches < 10)
                $display("unexpected result: dot_sum %0d row_tag 0x%08h",
                         got.dot_sum, got.row_tag);
            mismatches++;
            return;
        end
        want = expected_q.pop_front();
        if (got.dot_sum !== want.dot_sum || got.row_tag !== want.row_tag) begin
            if (mismatches < 10)
                $display("mismatch: dot_sum exp %0d got %0d, row_tag exp 0x%08h got 0x%08h",
                         want.dot_sum, got.dot_sum, want.row_tag, got.row_tag);
            mismatches++;
        end
    endfunction
endclass

module testbench;

    localparam int RANDOM_BEATS = 1700;
    localparam int SETTLE       = 16;
    localparam int LONG_HOLD    = 400;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_COIN,
        RX_SLOW,
        RX_PERIODIC
    } t_rx_style;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        i_cfg_wr_en   = 1'b0;
    logic [bidp_pkg::LEN_W-1:0]  i_cfg_wr_data = '0;
    logic                        push          = 1'b0;
    bidp_pkg::t_in_beat          i_in_beat     = '0;
    logic                        full;
    logic                        empty;
    logic                        pop           = 1'b0;
    bidp_pkg::t_out_beat         o_out_beat;

    dot_scoreboard      sb;

    // Sender pacing: bursts of random length, gaps of random length bounded by gap_max.
    int unsigned        burst_left = 0;
    int unsigned        gap_max    = 0;
    int unsigned        beats_sent = 0;

    // Receiver pacing, plus a one-time long hold to back the unit up.
    t_rx_style          rx_style   = RX_FREE;
    logic               hold_req   = 1'b0;
    logic               hold_done  = 1'b0;
    int unsigned        hold_left  = 0;
    logic [2:0]         rx_tick    = '0;

    bulk_int7_dot_product_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .push          (push),
        .i_in_beat     (i_in_beat),
        .full          (full),
        .empty         (empty),
        .pop           (pop),
        .o_out_beat    (o_out_beat)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Ends a hung run; the slowest legal run is several times shorter.
    initial begin
        #10_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // Receiver: the stall pattern follows rx_style; one long hold is taken on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left != 0) begin
            pop       <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            pop       <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else begin
            rx_tick <= rx_tick + 1'b1;
            case (rx_style)
                RX_FREE:  pop <= 1'b1;
                RX_COIN:  pop <= 1'($urandom_range(0, 1));
                RX_SLOW:  pop <= ($urandom_range(0, 3) == 0);
                default:  pop <= (rx_tick < 3'd5);
            endcase
        end
    end

    // Watch both handshakes; values seen here are the ones from before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) sb.note_beat(i_in_beat);
            if (pop && !empty) sb.check_result(o_out_beat);
        end
    end

    // Offer one beat and hold it until the unit takes it. A gap opens between bursts when gap_max is nonzero.
    task automatic send_beat(input bidp_pkg::t_mode mode,
                             input logic [bidp_pkg::ELEM_W-1:0] elem,
                             input logic [bidp_pkg::TAG_W-1:0] tag);
        if (burst_left == 0) begin
            if (gap_max != 0) begin
                push <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        push              <= 1'b1;
        i_in_beat.mode      <= mode;
        i_in_beat.element   <= elem;
        i_in_beat.row_index <= tag;
        do @(posedge i_clk); while (full);
        burst_left--;
        beats_sent++;
    endtask

    task automatic send_query(input logic [bidp_pkg::ELEM_W-1:0] elem);
        send_beat(bidp_pkg::MODE_QUERY, elem, bidp_pkg::TAG_W'($urandom()));
    endtask

    task automatic send_row(input logic [bidp_pkg::ELEM_W-1:0] elem,
                            input logic [bidp_pkg::TAG_W-1:0] tag);
        send_beat(bidp_pkg::MODE_ROW, elem, tag);
    endtask

    // Stop sending, let every expected result drain, then give the pipe time to empty.
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Length writes only go in while the unit is idle.
    task automatic write_length(input logic [bidp_pkg::LEN_W-1:0] len);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= len;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_length(len);
    endtask

    // Lean on the extremes so sums hit zero and the top of the range.
    function automatic logic [bidp_pkg::ELEM_W-1:0] pick_element();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return bidp_pkg::ELEM_W'($urandom_range(0, 127));
        endcase
    endfunction

    initial begin
        int unsigned                phase_no;
        int unsigned                eff;
        int unsigned                rows;
        int unsigned                n;
        logic [bidp_pkg::LEN_W-1:0] len;
        logic [bidp_pkg::TAG_W-1:0] row_tag;

        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset length of one, query overwrite, max and zero products.
        send_query(7'd127);
        send_row(7'd127, '1);
        send_row(7'd0, '0);
        send_query(7'd0);
        send_row(7'd127, 31'h5555_5555);

        // A written length of zero acts as one.
        write_length('0);
        send_query(7'd1);
        send_row(7'd127, 31'h2AAA_AAAA);

        // Length three: overfilled query, mid-row query load, tag changes mid-row,
        // and a partial row left behind when the length is rewritten.
        write_length(13'd3);
        send_query(7'd127);
        send_query(7'd0);
        send_query(7'd5);
        send_query(7'd9);
        send_row(7'd127, 31'd1);
        send_query(7'd127);
        send_row(7'd127, 31'd2);
        send_row(7'd3, 31'd3);
        send_row(7'd10, 31'd4);

        write_length(13'd2);
        send_query(7'd127);
        send_query(7'd127);
        send_row(7'd127, '1);
        send_row(7'd127, 31'd6);

        // Random phases: mostly whole rows after a full query load, with noise mixed in.
        n        = beats_sent + RANDOM_BEATS;
        phase_no = 0;
        while (beats_sent < n) begin
            case ($urandom_range(0, 19))
                0:       len = '0;
                1:       len = 13'd1;
                2:       len = bidp_pkg::LEN_W'($urandom_range(100, 300));
                3, 4, 5: len = bidp_pkg::LEN_W'($urandom_range(9, 40));
                default: len = bidp_pkg::LEN_W'($urandom_range(2, 8));
            endcase
            if (phase_no == 0) len = bidp_pkg::LEN_W'($urandom_range(1, 4));
            write_length(len);
            eff      = sb.span();
            gap_max  = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            rx_style = t_rx_style'($urandom_range(0, 3));
            rows     = (eff > 40) ? $urandom_range(1, 2) : $urandom_range(2, 10);

            for (int k = 0; k < eff; k++) send_query(pick_element());
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, eff)) send_query(pick_element());

            // Back the unit up once: receiver holds while the sender keeps pushing.
            if (phase_no == 0) begin
                gap_max  = 0;
                rows     = 12;
                hold_req <= 1'b1;
            end

            for (int r = 0; r < rows; r++) begin
                row_tag = bidp_pkg::TAG_W'($urandom());
                for (int p = 0; p < eff; p++) begin
                    if ($urandom_range(0, 19) == 0) send_query(pick_element());
                    if (p == eff - 1 || $urandom_range(0, 7) != 0)
                        send_row(pick_element(), row_tag);
                    else
                        send_row(pick_element(), bidp_pkg::TAG_W'($urandom()));
                end
            end

            // Leave a partial row for the next length write to discard.
            if ($urandom_range(0, 3) == 0 && eff > 1)
                repeat ($urandom_range(1, eff - 1))
                    send_row(pick_element(), bidp_pkg::TAG_W'($urandom()));
            phase_no++;
        end

        drain();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
